// ===== src/ttgd_pkg.sv =====
package ttgd_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SHORT_PRESS_LIMIT = 8'd0,
        REG_DOUBLE_TAP_WINDOW = 8'd1
    } cfg_reg_t;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] SHORT_PRESS_RESET   = 16'd500;
    localparam logic [CFG_DATA_W-1:0] DOUBLE_WINDOW_RESET = 16'd400;

    // Timestamp width
    localparam int TIME_W = 32;

endpackage

// ===== src/touch_tap_gesture_detector.sv =====
// Single/double tap detector for a stream of touch samples.
// Input channel (in_valid/in_ready): one item per sample, carrying the
// pressed level and a wrapping millisecond timestamp now_ms.
// Output channel (out_valid/out_ready): exactly one item per sample with
// single_tap, double_tap and tap_pending for that sample.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is the
// short-press limit, index 1 the double-tap window; other indexes are
// dropped. cfg_ready is always high.
// An accepted item passes the input register, then the result register,
// before it is shown. Throughput: one item per cycle unless the receiver
// stalls; the tap state is read and updated by a single
// subtract-and-compare step between the two registers.
// Reset clears the tap state and loads the register defaults (500, 400).
// When the receiver stalls, the result register holds and the input
// register fills; in_ready drops only when both are full, and rises in
// the same cycle out_ready returns.
module touch_tap_gesture_detector
    import ttgd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // sample input
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   pressed,
    input  logic [TIME_W-1:0]      now_ms,
    // result output
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   single_tap,
    output logic                   double_tap,
    output logic                   tap_pending,
    // configuration write
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Config registers
    logic [CFG_DATA_W-1:0] short_limit_reg;
    logic [CFG_DATA_W-1:0] window_reg;

    // Input stage
    logic              s1_valid_reg;
    logic              s1_pressed_reg;
    logic [TIME_W-1:0] s1_now_reg;
    logic              s1_advance;

    // Tap state
    logic              prev_pressed_reg;
    logic [TIME_W-1:0] press_start_reg;
    logic [TIME_W-1:0] last_tap_reg;
    logic              first_tap_reg;
    logic              prev_pressed_next;
    logic [TIME_W-1:0] press_start_next;
    logic [TIME_W-1:0] last_tap_next;
    logic              first_tap_next;

    // Result register
    logic out_valid_reg;
    logic single_tap_reg;
    logic double_tap_reg;
    logic tap_pending_reg;

    // Step signals
    logic              rise;
    logic              fall;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] gap;
    logic              short_tap;
    logic              dbl;
    logic              lapse;

    assign cfg_ready  = 1'b1;
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_limit_reg <= SHORT_PRESS_RESET;
            window_reg      <= DOUBLE_WINDOW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SHORT_PRESS_LIMIT: short_limit_reg <= cfg_data;
                REG_DOUBLE_TAP_WINDOW: window_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_pressed_reg <= pressed;
            s1_now_reg     <= now_ms;
        end
    end

    // Tap step: edge detect, press duration, tap gap, lapse
    always_comb
    begin
        rise      = s1_pressed_reg && !prev_pressed_reg;
        fall      = !s1_pressed_reg && prev_pressed_reg;
        held      = s1_now_reg - press_start_reg;
        gap       = s1_now_reg - last_tap_reg;
        short_tap = fall && (held < {{(TIME_W-CFG_DATA_W){1'b0}}, short_limit_reg});
        dbl       = short_tap && first_tap_reg
                    && (gap < {{(TIME_W-CFG_DATA_W){1'b0}}, window_reg});
        // a fresh pending tap has zero gap, so only an old one can lapse
        lapse     = !short_tap && first_tap_reg
                    && (gap > {{(TIME_W-CFG_DATA_W){1'b0}}, window_reg});

        prev_pressed_next = s1_pressed_reg;
        press_start_next  = rise ? s1_now_reg : press_start_reg;
        if (short_tap)
        begin
            first_tap_next = !dbl;
            last_tap_next  = dbl ? '0 : s1_now_reg;
        end
        else
        begin
            first_tap_next = first_tap_reg && !lapse;
            last_tap_next  = last_tap_reg;
        end
    end

    // State and result update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pressed_reg <= 1'b0;
            press_start_reg  <= '0;
            last_tap_reg     <= '0;
            first_tap_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                prev_pressed_reg <= prev_pressed_next;
                press_start_reg  <= press_start_next;
                last_tap_reg     <= last_tap_next;
                first_tap_reg    <= first_tap_next;
                out_valid_reg    <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            single_tap_reg  <= short_tap;
            double_tap_reg  <= dbl;
            tap_pending_reg <= first_tap_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign single_tap  = single_tap_reg;
    assign double_tap  = double_tap_reg;
    assign tap_pending = tap_pending_reg;

    // Assertions
    a_dbl_is_tap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && double_tap |-> single_tap)
        else $error("double tap without single tap");

    a_dbl_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && double_tap |-> !tap_pending)
        else $error("pending tap left after double tap");

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled with room in the pipe");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid_reg)
        else $error("advanced item did not reach result register");

    a_pending_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> tap_pending_reg == first_tap_reg)
        else $error("pending flag differs from tap state");

endmodule
